// ===== design/cte_pkg.sv =====
// shared types, constants and helpers for the calendar to epoch seconds core
package cte_pkg;

   localparam int FIELD_W = 16;
   localparam int TOD_W   = 28;
   localparam int DAYS_W  = 26;
   localparam int SECS_W  = 44;
   localparam int OUT_W   = 63;

   localparam logic signed [16:0] YEAR_BASE = 17'sd1900;
   localparam logic signed [17:0] YEAR_MIN  = 18'sd1582;
   localparam logic signed [DAYS_W-1:0] EPOCH_DAY = 26'sd719528;
   localparam logic signed [DAYS_W-1:0] DAYS_PER_YEAR = 26'sd365;
   localparam logic signed [DAYS_W-1:0] DAYS_PER_MONTH = 26'sd31;

   // month + 32768 + 4 is a multiple-of-twelve offset of 12 * 2731
   localparam logic [16:0] MONTH_BIAS = 17'd4;
   localparam logic signed [13:0] Q_BIAS = 14'sd2731;
   localparam logic signed [17:0] MONTHS_PER_YEAR = 18'sd12;

   // reciprocal constants, exact over the value ranges seen here
   localparam logic [16:0] RECIP12 = 17'd87382;
   localparam int RECIP12_SHIFT = 20;
   localparam int Q_W = 13;
   localparam logic [12:0] RECIP100 = 13'd5243;
   localparam int RECIP100_SHIFT = 19;
   localparam int C100_W = 9;

   localparam logic signed [TOD_W-1:0] MINUTE_SECONDS = 28'sd60;
   localparam logic signed [TOD_W-1:0] HOUR_SECONDS   = 28'sd3600;
   localparam logic signed [17:0] DAY_SECONDS = 18'sd86400;

   localparam logic [OUT_W-1:0] MAX_SECONDS_RESET = 63'd2147483647;

   typedef struct packed {
      logic signed [FIELD_W-1:0] year_offset;
      logic signed [FIELD_W-1:0] month_index;
      logic signed [FIELD_W-1:0] month_day;
      logic signed [FIELD_W-1:0] hours;
      logic signed [FIELD_W-1:0] minutes;
      logic signed [FIELD_W-1:0] seconds_in;
   } req_type;

   typedef struct packed {
      logic signed [16:0]       year;
      logic [Q_W-1:0]           qraw;
      logic signed [FIELD_W-1:0] mon;
      logic signed [FIELD_W-1:0] mday;
      logic signed [TOD_W-1:0]  tod;
   } s1_type;

   typedef struct packed {
      logic                     bad;
      logic [15:0]              year;
      logic [3:0]               mon;
      logic signed [FIELD_W-1:0] mday;
      logic signed [TOD_W-1:0]  tod;
   } s2_type;

   typedef struct packed {
      logic                     bad;
      logic [15:0]              yadj;
      logic [C100_W-1:0]        c100;
      logic signed [DAYS_W-1:0] base;
      logic signed [TOD_W-1:0]  tod;
   } s3_type;

   typedef struct packed {
      logic                     bad;
      logic signed [DAYS_W-1:0] days;
      logic signed [TOD_W-1:0]  tod;
   } s4_type;

   // days lost before the first of a month from march on
   function automatic logic [2:0] month_adjust(input logic [3:0] mon);
      logic [2:0] adj;
      adj = 3'd0;
      case (mon)
         4'd2, 4'd3:        adj = 3'd3;
         4'd4, 4'd5:        adj = 3'd4;
         4'd6, 4'd7, 4'd8:  adj = 3'd5;
         4'd9, 4'd10:       adj = 3'd6;
         4'd11:             adj = 3'd7;
         default:           adj = 3'd0;
      endcase
      return adj;
   endfunction

endpackage

// ===== design/calendar_to_epoch_seconds_core.sv =====
// top level: calendar date and time to epoch seconds, six stage pipeline
//
// usage
//   req channel: one beat carries a broken-down gregorian date and time
//     (year minus 1900, month from 0, day, hours, minutes, seconds, all
//     16 bit two's complement, month may lie outside 0 to 11)
//   rsp channel: one beat per request, in order: seconds since 1970-01-01
//     00:00:00 (no zone adjustment) in tdata, invalid flag in tuser;
//     invalid beats carry zero seconds
//   csr channel: writes max_seconds (always ready); results above it are
//     flagged invalid; write only while no request is in flight
//   latency: a request accepted at one edge shows on rsp 5 cycles later,
//     set by the six register stages, the first loaded at the accepting edge
//     (month fold, year check, day terms, leap terms, 86400 multiply, add and compare)
//   throughput: one beat per cycle sustained
//   reset: empties the pipeline and loads max_seconds with 2147483647
//   stall: when rsp_tready is low the result holds in the output register;
//     upstream stages keep filling bubbles, req_tready drops only once
//     every stage holds a beat
module calendar_to_epoch_seconds_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: year_offset, month_index, month_day, hours, minutes, seconds_in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   // rsp_tdata: epoch_seconds[62:0], zero pad bit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // rsp_tuser: invalid
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [62:0] csr_data
);
   import cte_pkg::*;

   req_type req_data;
   logic    front_valid, front_ready;
   s2_type  front_data;
   logic    days_valid, days_ready;
   s4_type  days_data;

   // stage 5 and output stage
   logic                     v5_ff, v6_ff;
   logic                     adv5, adv6;
   logic                     bad5_ff;
   logic signed [SECS_W-1:0] secs5_ff, secs5_in;
   logic signed [TOD_W-1:0]  tod5_ff;
   logic signed [SECS_W:0]   total;
   logic                     invalid_in;
   logic                     invalid_ff;
   logic [OUT_W-1:0]         epoch_in, epoch_ff;
   logic [OUT_W-1:0]         max_seconds_ff;

   // unpack the request beat, first field in the low bits
   assign req_data.year_offset = req_tdata[15:0];
   assign req_data.month_index = req_tdata[31:16];
   assign req_data.month_day   = req_tdata[47:32];
   assign req_data.hours       = req_tdata[63:48];
   assign req_data.minutes     = req_tdata[79:64];
   assign req_data.seconds_in  = req_tdata[95:80];

   cte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   cte_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (days_valid),
      .out_ready (days_ready),
      .out_data  (days_data)
   );

   // each stage moves when it is empty or the next one moves
   assign adv6       = !v6_ff || rsp_tready;
   assign adv5       = !v5_ff || adv6;
   assign days_ready = adv5;

   // day count scaled to seconds
   assign secs5_in = days_data.days * DAY_SECONDS;

   // add time of day, then sign and maximum check
   always_comb begin
      total      = (SECS_W+1)'(secs5_ff) + (SECS_W+1)'(tod5_ff);
      invalid_in = bad5_ff || total[SECS_W]
                || (OUT_W'(total[SECS_W-1:0]) > max_seconds_ff);
      epoch_in   = invalid_in ? '0 : OUT_W'(total[SECS_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff          <= 1'b0;
         v6_ff          <= 1'b0;
         max_seconds_ff <= MAX_SECONDS_RESET;
      end else begin
         if (adv5) v5_ff <= days_valid;
         if (adv6) v6_ff <= v5_ff;
         if (csr_valid) max_seconds_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         bad5_ff  <= days_data.bad;
         secs5_ff <= secs5_in;
         tod5_ff  <= days_data.tod;
      end
      if (adv6) begin
         invalid_ff <= invalid_in;
         epoch_ff   <= epoch_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {1'b0, epoch_ff};
   assign rsp_tuser  = invalid_ff;

`ifndef NO_ASSERTIONS
   // an invalid beat carries no seconds
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("invalid result with nonzero seconds");

   // a valid beat never exceeds the configured maximum
   a_within_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[62:0] <= max_seconds_ff)
      else $error("valid result above max_seconds");

   // an empty output register lets the whole pipe move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with free output stage");

   // a beat leaving stage five lands in the output register
   a_stage_handoff: assert property (@(posedge clock) disable iff (reset)
      v5_ff && adv6 |=> rsp_tvalid)
      else $error("beat lost between last two stages");
`endif

endmodule

// ===== design/cte_front.sv =====
// input stages: year rebase, month fold into the year, time of day
module cte_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cte_pkg::req_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output cte_pkg::s2_type out_data
);
   import cte_pkg::*;

   logic   v1_ff, v2_ff;
   logic   adv1, adv2;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;

   logic [16:0]              u;
   logic [33:0]              qprod;
   logic signed [13:0]       qs;
   logic signed [17:0]       year_n;
   logic signed [17:0]       mon_n;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // stage 1: biased floor(month / 12) by reciprocal, year rebase, time of day
   always_comb begin
      u     = 17'({~in_data.month_index[15], in_data.month_index[14:0]}) + MONTH_BIAS;
      qprod = u * RECIP12;
      s1_in.year = 17'(in_data.year_offset) + YEAR_BASE;
      s1_in.qraw = qprod[RECIP12_SHIFT +: Q_W];
      s1_in.mon  = in_data.month_index;
      s1_in.mday = in_data.month_day;
      s1_in.tod  = TOD_W'(in_data.seconds_in)
                 + TOD_W'(in_data.minutes) * MINUTE_SECONDS
                 + TOD_W'(in_data.hours) * HOUR_SECONDS;
   end

   // stage 2: normalized year and month, minimum year check
   always_comb begin
      qs     = $signed({1'b0, s1_ff.qraw}) - Q_BIAS;
      year_n = 18'(s1_ff.year) + 18'(qs);
      mon_n  = 18'(s1_ff.mon) - 18'(qs) * MONTHS_PER_YEAR;
      s2_in.bad  = year_n < YEAR_MIN;
      s2_in.year = year_n[15:0];
      s2_in.mon  = mon_n[3:0];
      s2_in.mday = s1_ff.mday;
      s2_in.tod  = s1_ff.tod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

// ===== design/cte_days.sv =====
// day number stages: gregorian day count rebased to the epoch
module cte_days (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cte_pkg::s2_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output cte_pkg::s4_type out_data
);
   import cte_pkg::*;

   logic   v3_ff, v4_ff;
   logic   adv3, adv4;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;

   logic [28:0] cprod;
   logic [10:0] leap_corr;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;

   // stage 3: linear day terms, year / 100 by reciprocal
   always_comb begin
      s3_in.bad  = in_data.bad;
      s3_in.yadj = (in_data.mon < 4'd2) ? in_data.year - 16'd1 : in_data.year;
      cprod      = s3_in.yadj * RECIP100;
      s3_in.c100 = cprod[RECIP100_SHIFT +: C100_W];
      s3_in.base = $signed(DAYS_W'(in_data.year)) * DAYS_PER_YEAR
                 + DAYS_W'(in_data.mday)
                 + $signed(DAYS_W'(in_data.mon)) * DAYS_PER_MONTH
                 - $signed(DAYS_W'(month_adjust(in_data.mon)));
      s3_in.tod  = in_data.tod;
   end

   // stage 4: leap day terms and epoch rebase
   always_comb begin
      leap_corr  = ((11'(s3_ff.c100) + 11'd1) * 11'd3) >> 2;
      s4_in.bad  = s3_ff.bad;
      s4_in.days = s3_ff.base
                 + $signed(DAYS_W'(s3_ff.yadj >> 2))
                 - $signed(DAYS_W'(leap_corr))
                 - EPOCH_DAY;
      s4_in.tod  = s3_ff.tod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv3) v3_ff <= in_valid;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) s3_ff <= s3_in;
      if (adv4) s4_ff <= s4_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule
